// ----- hw/rtl/prm_pkg.sv -----
// ----------------------------------------------------------------------------
// prm_pkg: shared definitions for the polynomial remainder block
// Coefficient widths, register codes and the request/response structs of the
// shared modular multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package prm_pkg;

    // coefficient and configuration geometry
    localparam int COEFF_BITS     = 8;
    localparam int N_BITS         = COEFF_BITS + 1;
    localparam int DIV_TERMS      = 7;
    localparam int DEG_BITS       = 3;
    localparam int IDX_OUT_BITS   = 3;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = DIV_TERMS * COEFF_BITS;
    localparam int STEP_CNT_BITS  = $clog2(COEFF_BITS);
    localparam int DEGREE_CAP_DEF = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS        = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIVISOR_DEGREE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIVISOR_COEFFS = 2'd2;

    // configuration reset values
    localparam logic [COEFF_BITS-1:0]    MODULUS_RESET = 8'd2;
    localparam logic [DEG_BITS-1:0]      DEGREE_RESET  = 3'd1;
    localparam logic [CFG_DATA_BITS-1:0] COEFFS_RESET  = '0;

    // ring settings handed to the core
    typedef struct packed {
        logic [N_BITS-1:0]        n;
        logic [CFG_DATA_BITS-1:0] g;
    } ring_cfg_t;

    // request to the modular multiply unit: result = (a * b) mod n
    typedef struct packed {
        logic                  start;
        logic [COEFF_BITS-1:0] a;
        logic [COEFF_BITS-1:0] b;
        logic [N_BITS-1:0]     n;
    } mm_req_t;

    typedef struct packed {
        logic                  done;
        logic [COEFF_BITS-1:0] result;
    } mm_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/prm_ifs.sv -----
// ----------------------------------------------------------------------------
// prm_ifs: channel interfaces of the polynomial remainder block
// Dividend coefficient input, remainder coefficient output and config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface prm_coeff_if import prm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COEFF_BITS-1:0] coefficient;
    logic                  last_coefficient;

    modport source (output valid, coefficient, last_coefficient, input ready);
    modport sink   (input valid, coefficient, last_coefficient, output ready);
endinterface

interface prm_rem_if import prm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [COEFF_BITS-1:0]   remainder_coefficient;
    logic [IDX_OUT_BITS-1:0] coefficient_index;
    logic                    last_of_run;

    modport source (output valid, remainder_coefficient, coefficient_index, last_of_run,
                    input ready);
    modport sink   (input valid, remainder_coefficient, coefficient_index, last_of_run,
                    output ready);
endinterface

interface prm_cfg_if import prm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/poly_remainder_mod_n_top.sv -----
// ----------------------------------------------------------------------------
// poly_remainder_mod_n_top: polynomial remainder modulo a monic divisor
// Config registers, ring modulus decode and the division engine.
// ----------------------------------------------------------------------------
// Dividend coefficients enter highest degree first, one request at a time; the
// request marked last ends the dividend and the remainder leaves lowest degree
// first with last_of_run on its final coefficient. Every modular product and
// reduction runs on one bit-serial multiplier that needs 8 steps; with divisor
// degree d >= 1 a coefficient takes 2d + 1 multiplier operations, and a
// constant divisor needs none. The input is not ready while a coefficient is
// in work; the output register lets the next dividend start while the final
// result waits. Config writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_remainder_mod_n_top import prm_pkg::*;
#(
    parameter int DEGREE_CAP = DEGREE_CAP_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    prm_coeff_if.sink coeff,
    prm_rem_if.source remainder,
    prm_cfg_if.sink   cfg
);

    logic [COEFF_BITS-1:0]    modulus_reg;
    logic [DEG_BITS-1:0]      degree_reg;
    logic [CFG_DATA_BITS-1:0] coeffs_reg;
    ring_cfg_t                ring;
    mm_req_t                  mm_req;
    mm_rsp_t                  mm_rsp;

    assign cfg.ready = 1'b1;

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
            degree_reg  <= DEGREE_RESET;
            coeffs_reg  <= COEFFS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_MODULUS:        modulus_reg <= cfg.data[COEFF_BITS-1:0];
                CFG_DIVISOR_DEGREE: degree_reg  <= cfg.data[DEG_BITS-1:0];
                CFG_DIVISOR_COEFFS: coeffs_reg  <= cfg.data;
                default:            ;
            endcase
        end
    end

    // modulus zero means the full 2^COEFF_BITS ring
    assign ring.n = (modulus_reg == '0) ? {1'b1, {COEFF_BITS{1'b0}}} : N_BITS'(modulus_reg);
    assign ring.g = coeffs_reg;

    prm_core #(
        .DEGREE_CAP (DEGREE_CAP)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .coeff     (coeff),
        .remainder (remainder),
        .ring      (ring),
        .degree    (degree_reg),
        .mm_req    (mm_req),
        .mm_rsp    (mm_rsp)
    );

    prm_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/prm_mulmod.sv -----
// ----------------------------------------------------------------------------
// prm_mulmod: bit-serial modular multiplier
// Computes (a * b) mod n by Horner steps over the bits of b, MSB first,
// one doubling-add-reduce per cycle. With a = 1 it reduces b mod n.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_mulmod import prm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire mm_req_t req,
    output mm_rsp_t      rsp
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_CNT_BITS-1:0] cnt_reg;
    logic [COEFF_BITS-1:0]    acc_reg;
    logic [COEFF_BITS-1:0]    a_reg;
    logic [COEFF_BITS-1:0]    b_reg;

    logic [N_BITS:0]          sum;
    logic [N_BITS:0]          two_n;
    logic [N_BITS:0]          one_n;
    logic [N_BITS:0]          step;

    // double, add a when the current bit of b is set, then fold below n
    always_comb
    begin
        one_n = (N_BITS + 1)'(req.n);
        two_n = {req.n, 1'b0};
        sum   = (N_BITS + 1)'({acc_reg, 1'b0})
              + (N_BITS + 1)'(b_reg[COEFF_BITS-1] ? a_reg : '0);
        if (sum >= two_n)
        begin
            step = sum - two_n;
        end
        else if (sum >= one_n)
        begin
            step = sum - one_n;
        end
        else
        begin
            step = sum;
        end
    end

    // step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_CNT_BITS'(COEFF_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
        end
        else if (busy_reg)
        begin
            acc_reg <= COEFF_BITS'(step);
            b_reg   <= {b_reg[COEFF_BITS-2:0], 1'b0};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/prm_core.sv -----
// ----------------------------------------------------------------------------
// prm_core: division sequencer and remainder store
// Walks the remainder positions from the top down for each dividend
// coefficient, driving the shared modular multiplier, and streams out the
// remainder lowest degree first when the dividend ends.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_core import prm_pkg::*;
#(
    parameter int DEGREE_CAP = DEGREE_CAP_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    prm_coeff_if.sink                coeff,
    prm_rem_if.source                remainder,
    input  wire ring_cfg_t           ring,
    input  wire logic [DEG_BITS-1:0] degree,
    output mm_req_t                  mm_req,
    input  wire mm_rsp_t             mm_rsp
);

    localparam int IW = (DEGREE_CAP > 1) ? $clog2(DEGREE_CAP) : 1;
    localparam int DW = $clog2(DEGREE_CAP + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TOP   = 3'd1;
    localparam logic [2:0] S_BELOW = 3'd2;
    localparam logic [2:0] S_SUB   = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]            state_reg,   state_next;
    logic [IW-1:0]         idx_reg,     idx_next;
    logic [IW-1:0]         emit_reg,    emit_next;
    logic [DW-1:0]         deg_reg,     deg_next;
    logic                  last_reg,    last_next;
    logic                  start_reg,   start_next;
    logic                  op_mul_reg,  op_mul_next;
    logic                  op_coef_reg, op_coef_next;
    logic                  out_valid_reg;
    logic [COEFF_BITS-1:0] coef_reg,    coef_next;
    logic [COEFF_BITS-1:0] top_reg,     top_next;
    logic [COEFF_BITS-1:0] below_reg,   below_next;
    logic [COEFF_BITS-1:0] out_value_reg;
    logic [IW-1:0]         out_index_reg;
    logic                  out_last_reg;

    // remainder store with per-entry valid bits
    logic [COEFF_BITS-1:0] mem [DEGREE_CAP];
    logic [DEGREE_CAP-1:0] valid_reg;
    logic [COEFF_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic [IW-1:0]         rd_addr;
    logic [IW-1:0]         wr_addr;
    logic [COEFF_BITS-1:0] wr_data;
    logic                  wr_en;
    logic                  clear;

    logic                  accept;
    logic                  out_load;
    logic                  emit_last;
    logic [DW-1:0]         deg_clamp;
    logic [COEFF_BITS-1:0] rd_value;
    logic [COEFF_BITS-1:0] g_sel;
    logic [COEFF_BITS-1:0] one_red;
    logic [N_BITS:0]       diff;
    logic [N_BITS:0]       diff_red;

    assign accept      = coeff.valid && coeff.ready;
    assign coeff.ready = (state_reg == S_IDLE);
    assign deg_clamp   = (int'(degree) > DEGREE_CAP) ? DW'(DEGREE_CAP) : DW'(degree);
    assign rd_value    = rd_valid_reg ? rd_data_reg : '0;
    assign one_red     = (ring.n == N_BITS'(1)) ? '0 : COEFF_BITS'(1);
    assign out_load    = !out_valid_reg || remainder.ready;
    assign emit_last   = (deg_reg == '0) || ((DW'(emit_reg) + DW'(1)) == deg_reg);

    // pick the divisor coefficient of the current position
    always_comb
    begin
        g_sel = '0;
        for (int k = 0; k < DIV_TERMS; k++)
        begin
            if (int'(idx_reg) == k)
            begin
                g_sel = ring.g[k*COEFF_BITS +: COEFF_BITS];
            end
        end
    end

    // new position value: (below - top * g) mod n, both terms already reduced
    always_comb
    begin
        diff = (N_BITS + 1)'(below_reg) + (N_BITS + 1)'(ring.n)
             - (N_BITS + 1)'(mm_rsp.result);
        if (diff >= (N_BITS + 1)'(ring.n))
        begin
            diff_red = diff - (N_BITS + 1)'(ring.n);
        end
        else
        begin
            diff_red = diff;
        end
    end

    // shared unit request
    assign mm_req.start = start_reg;
    assign mm_req.a     = op_mul_reg ? top_reg : one_red;
    assign mm_req.b     = op_mul_reg ? g_sel : (op_coef_reg ? coef_reg : rd_value);
    assign mm_req.n     = ring.n;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        emit_next    = emit_reg;
        deg_next     = deg_reg;
        last_next    = last_reg;
        coef_next    = coef_reg;
        top_next     = top_reg;
        below_next   = below_reg;
        start_next   = 1'b0;
        op_mul_next  = op_mul_reg;
        op_coef_next = op_coef_reg;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = COEFF_BITS'(diff_red);
        clear        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    coef_next = coeff.coefficient;
                    last_next = coeff.last_coefficient;
                    deg_next  = deg_clamp;
                    if (deg_clamp == '0)
                    begin
                        if (coeff.last_coefficient)
                        begin
                            emit_next  = '0;
                            state_next = S_FETCH;
                        end
                    end
                    else
                    begin
                        // reduce the outgoing top coefficient first
                        rd_addr      = IW'(deg_clamp - DW'(1));
                        start_next   = 1'b1;
                        op_mul_next  = 1'b0;
                        op_coef_next = 1'b0;
                        state_next   = S_TOP;
                    end
                end
            end
            S_TOP:
            begin
                if (mm_rsp.done)
                begin
                    top_next     = mm_rsp.result;
                    idx_next     = IW'(deg_reg - DW'(1));
                    start_next   = 1'b1;
                    op_mul_next  = 1'b0;
                    op_coef_next = (deg_reg == DW'(1));
                    rd_addr      = IW'(deg_reg - DW'(2));
                    state_next   = S_BELOW;
                end
            end
            S_BELOW:
            begin
                if (mm_rsp.done)
                begin
                    below_next  = mm_rsp.result;
                    start_next  = 1'b1;
                    op_mul_next = 1'b1;
                    state_next  = S_SUB;
                end
            end
            S_SUB:
            begin
                if (mm_rsp.done)
                begin
                    wr_en = 1'b1;
                    if (idx_reg == '0)
                    begin
                        if (last_reg)
                        begin
                            emit_next  = '0;
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        // advance one position down; position zero takes the input
                        idx_next     = idx_reg - 1'b1;
                        start_next   = 1'b1;
                        op_mul_next  = 1'b0;
                        op_coef_next = (idx_reg == IW'(1));
                        rd_addr      = idx_reg - IW'(2);
                        state_next   = S_BELOW;
                    end
                end
            end
            S_FETCH:
            begin
                rd_addr    = emit_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                rd_addr = emit_reg;
                if (out_load)
                begin
                    if (emit_last)
                    begin
                        clear      = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg + 1'b1;
                        rd_addr   = emit_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            start_reg    <= start_next;
            rd_valid_reg <= valid_reg[rd_addr];
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (state_reg == S_EMIT && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (remainder.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        emit_reg    <= emit_next;
        deg_reg     <= deg_next;
        last_reg    <= last_next;
        coef_reg    <= coef_next;
        top_reg     <= top_next;
        below_reg   <= below_next;
        op_mul_reg  <= op_mul_next;
        op_coef_reg <= op_coef_next;
        if (state_reg == S_EMIT && out_load)
        begin
            out_value_reg <= (deg_reg == '0) ? '0 : rd_value;
            out_index_reg <= emit_reg;
            out_last_reg  <= emit_last;
        end
    end

    // remainder store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign remainder.valid                 = out_valid_reg;
    assign remainder.remainder_coefficient = out_value_reg;
    assign remainder.coefficient_index     = IDX_OUT_BITS'(out_index_reg);
    assign remainder.last_of_run           = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/prm_checker.sv -----
// ----------------------------------------------------------------------------
// prm_checker: port-level checks for the polynomial remainder block
// Watches the coefficient and remainder channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_checker import prm_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    in_last,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [COEFF_BITS-1:0]   out_value,
    input wire logic [IDX_OUT_BITS-1:0] out_index,
    input wire logic                    out_last
);

    // hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index))
    else $error("stalled remainder request changed");

    // the last coefficient always starts work, so the input closes
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after last coefficient");

    // a run streams without gaps and with rising degree
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=>
            out_valid && out_index == $past(out_index) + 1'b1)
    else $error("remainder run broke or skipped a degree");

    // no new dividend while a run is still being streamed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
    else $error("input accepted in the middle of a remainder run");

endmodule

bind poly_remainder_mod_n_top prm_checker u_prm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (coeff.valid),
    .in_ready  (coeff.ready),
    .in_last   (coeff.last_coefficient),
    .out_valid (remainder.valid),
    .out_ready (remainder.ready),
    .out_value (remainder.remainder_coefficient),
    .out_index (remainder.coefficient_index),
    .out_last  (remainder.last_of_run)
);

`default_nettype wire

// ----- dv/prm_remainder_checker.sv -----
// ----------------------------------------------------------------------------
// prm_remainder_checker: remainder predictor and scoreboard
// Watches the config, coefficient and remainder channels of the polynomial
// remainder block. It keeps its own copy of the ring settings and of the
// partial remainder, and queues the remainder terms that each accepted
// coefficient request produces. Each accepted remainder request is then
// compared with the oldest queued term.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_remainder_checker import prm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    prm_coeff_if      coeff,
    prm_rem_if        remainder,
    prm_cfg_if        cfg,
    output int        error_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [COEFF_BITS-1:0]   value;
        logic [IDX_OUT_BITS-1:0] degree;
        logic                    last;
    } rem_term_t;

    // shadow of the ring settings
    logic [COEFF_BITS-1:0]    modulus_r;
    logic [DEG_BITS-1:0]      degree_r;
    logic [CFG_DATA_BITS-1:0] divisor_r;

    // partial remainder, lowest degree at index 0
    int unsigned partial_rem [DIV_TERMS];

    rem_term_t expected_terms_q [$];
    rem_term_t want_term;
    rem_term_t got_term;

    // Shift one dividend coefficient through the divisor and queue the
    // remainder terms when the dividend ends.
    task automatic divide_coefficient(input logic [COEFF_BITS-1:0] coeff_in,
                                      input logic is_last);
        int unsigned n;
        int unsigned top;
        int unsigned below;
        int unsigned sub;
        int unsigned c;
        int          d;
        int          i;
        rem_term_t   term;
        n = (modulus_r == '0) ? (32'd1 << COEFF_BITS) : 32'(modulus_r);
        d = int'(degree_r);
        c = 32'(coeff_in) % n;
        if (d > 0)
        begin
            top = partial_rem[d-1] % n;
            // walk down so each position still reads the old value below it
            for (i = d - 1; i >= 0; i--)
            begin
                below = (i == 0) ? c : partial_rem[i-1] % n;
                sub = (top * (32'(divisor_r[i*COEFF_BITS +: COEFF_BITS]) % n)) % n;
                partial_rem[i] = (below + n - sub) % n;
            end
        end
        if (is_last)
        begin
            if (d == 0)
            begin
                // a constant divisor leaves the zero polynomial
                term.value  = '0;
                term.degree = '0;
                term.last   = 1'b1;
                expected_terms_q.insert(expected_terms_q.size(), term);
            end
            else
            begin
                for (i = 0; i < d; i++)
                begin
                    term.value  = COEFF_BITS'(partial_rem[i] % n);
                    term.degree = IDX_OUT_BITS'(i);
                    term.last   = (i == d - 1);
                    expected_terms_q.insert(expected_terms_q.size(), term);
                end
            end
            for (i = 0; i < DIV_TERMS; i++)
                partial_rem[i] = 0;
        end
    endtask

    // Track settings, predict on coefficient requests, score remainder requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_r = MODULUS_RESET;
            degree_r  = DEGREE_RESET;
            divisor_r = COEFFS_RESET;
            for (int k = 0; k < DIV_TERMS; k++)
                partial_rem[k] = 0;
            expected_terms_q.delete();
            error_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_MODULUS:        modulus_r = cfg.data[COEFF_BITS-1:0];
                    CFG_DIVISOR_DEGREE: degree_r  = cfg.data[DEG_BITS-1:0];
                    CFG_DIVISOR_COEFFS: divisor_r = cfg.data;
                    default:            ;
                endcase
            end

            if (coeff.valid && coeff.ready)
                divide_coefficient(coeff.coefficient, coeff.last_coefficient);

            if (remainder.valid && remainder.ready)
            begin
                got_term = {remainder.remainder_coefficient, remainder.coefficient_index,
                            remainder.last_of_run};
                if (expected_terms_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected remainder term: coeff %0d degree %0d last %0d",
                                 $time, got_term.value, got_term.degree, got_term.last);
                end
                else
                begin
                    want_term = expected_terms_q.pop_front();
                    if (got_term !== want_term)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display({"%0t: remainder mismatch: expected coeff %0d degree %0d ",
                                      "last %0d, got coeff %0d degree %0d last %0d"},
                                     $time, want_term.value, want_term.degree, want_term.last,
                                     got_term.value, got_term.degree, got_term.last);
                    end
                end
            end
        end
        pending_count = expected_terms_q.size();
    end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top for the polynomial remainder block
// Drives dividend coefficient requests and config writes, stalls the remainder
// side, and reports the verdict. A short directed run covers the ring and
// divisor extremes, a constant divisor, unreduced values and a modulus change
// in the middle of a dividend; random dividends under varied settings and
// handshake pressure follow. Checking lives in prm_remainder_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int RANDOM_ITEMS   = 360;
    localparam int ROUND_ITEMS    = 30;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int error_count;
    int pending_count;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int idle_cycles    = 0;
    int coeffs_sent    = 0;
    int ring_n         = 2;

    always #4 clk = ~clk;

    prm_coeff_if coeff_ch ();
    prm_rem_if   rem_ch ();
    prm_cfg_if   cfg_ch ();

    poly_remainder_mod_n_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .coeff     (coeff_ch),
        .remainder (rem_ch),
        .cfg       (cfg_ch)
    );

    prm_remainder_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .coeff         (coeff_ch),
        .remainder     (rem_ch),
        .cfg           (cfg_ch),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Stall the remainder side at the current rate.
    always @(negedge clk)
        rem_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    // End the run when no channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (coeff_ch.valid && coeff_ch.ready) || (rem_ch.valid && rem_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Send one coefficient request; entered and left at a falling edge.
    task automatic send_coefficient(input logic [COEFF_BITS-1:0] value, input logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            coeff_ch.valid <= 1'b0;
            @(negedge clk);
        end
        coeff_ch.valid            <= 1'b1;
        coeff_ch.coefficient      <= value;
        coeff_ch.last_coefficient <= is_last;
        do @(posedge clk); while (!coeff_ch.ready);
        @(negedge clk);
        coeffs_sent++;
    endtask

    // Write one config register and drop the request afterwards.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Upper data bits are don't-care for the narrow registers: randomize them.
    task automatic set_modulus(input logic [COEFF_BITS-1:0] m);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        write_register(CFG_MODULUS, {noise[CFG_DATA_BITS-1:COEFF_BITS], m});
        ring_n = (m == '0) ? (1 << COEFF_BITS) : int'(m);
    endtask

    task automatic set_degree(input logic [DEG_BITS-1:0] d);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        write_register(CFG_DIVISOR_DEGREE, {noise[CFG_DATA_BITS-1:DEG_BITS], d});
    endtask

    // Hold off coefficients until every queued remainder term has come back.
    task automatic wait_drained();
        coeff_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
    endtask

    // Drain, then give a coefficient still in work time to finish.
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [COEFF_BITS-1:0] random_coefficient();
        if ($urandom_range(5) == 0)
            return COEFF_BITS'($urandom_range(255));
        return COEFF_BITS'($urandom_range(ring_n - 1));
    endfunction

    task automatic randomize_settings();
        logic [COEFF_BITS-1:0]    m;
        logic [CFG_DATA_BITS-1:0] g;
        case ($urandom_range(9))
            0:       m = 8'd0;
            1:       m = 8'd1;
            2:       m = 8'd2;
            3:       m = 8'd255;
            default: m = COEFF_BITS'($urandom_range(254, 3));
        endcase
        set_modulus(m);
        set_degree(DEG_BITS'($urandom_range(7)));
        // mostly reduced divisor terms, some at or above the modulus
        for (int b = 0; b < DIV_TERMS; b++)
            g[b*COEFF_BITS +: COEFF_BITS] = ($urandom_range(3) == 0) ?
                COEFF_BITS'($urandom_range(255)) : COEFF_BITS'($urandom_range(ring_n - 1));
        write_register(CFG_DIVISOR_COEFFS, g);
    endtask

    initial
    begin
        int round;
        int round_start;
        int len;

        coeff_ch.valid            = 1'b0;
        coeff_ch.coefficient      = '0;
        coeff_ch.last_coefficient = 1'b0;
        rem_ch.ready              = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = '0;
        cfg_ch.data               = '0;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // settings straight out of reset
        send_coefficient(8'd1, 1'b0);
        send_coefficient(8'd0, 1'b1);
        settle();

        // largest nonzero modulus, highest degree, largest reduced divisor terms
        set_modulus(8'd255);
        set_degree(3'd7);
        write_register(CFG_DIVISOR_COEFFS, {DIV_TERMS{8'hFE}});
        send_coefficient(8'd255, 1'b0);
        send_coefficient(8'd254, 1'b0);
        send_coefficient(8'd0,   1'b0);
        send_coefficient(8'd1,   1'b0);
        send_coefficient(8'd200, 1'b0);
        send_coefficient(8'd77,  1'b0);
        send_coefficient(8'd3,   1'b0);
        send_coefficient(8'd128, 1'b0);
        send_coefficient(8'd254, 1'b1);
        settle();

        // modulus zero means the full 2^COEFF_BITS ring
        write_register(CFG_DIVISOR_COEFFS, {DIV_TERMS{8'hFF}});
        set_modulus(8'd0);
        send_coefficient(8'd255, 1'b0);
        send_coefficient(8'd255, 1'b0);
        send_coefficient(8'd255, 1'b1);
        settle();

        // trivial ring
        set_modulus(8'd1);
        set_degree(3'd3);
        send_coefficient(8'd5, 1'b0);
        send_coefficient(8'd9, 1'b1);
        settle();

        // constant divisor: a single zero term
        set_modulus(8'd7);
        set_degree(3'd0);
        send_coefficient(8'd3,   1'b0);
        send_coefficient(8'd200, 1'b1);
        settle();

        // shrink the modulus in the middle of a dividend
        set_modulus(8'd251);
        set_degree(3'd2);
        write_register(CFG_DIVISOR_COEFFS, {40'd0, 8'd200, 8'd250});
        send_coefficient(8'd250, 1'b0);
        send_coefficient(8'd100, 1'b0);
        send_coefficient(8'd37,  1'b0);
        settle();
        set_modulus(8'd7);
        send_coefficient(8'd6,   1'b0);
        send_coefficient(8'd255, 1'b1);
        settle();

        // random dividends, rotating the handshake pressure each round
        coeffs_sent = 0;
        round = 0;
        while (coeffs_sent < RANDOM_ITEMS)
        begin
            case (round % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
                1:       begin src_idle_pct = 83; sink_stall_pct <= 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct <= 83; end
                default: begin src_idle_pct = 25; sink_stall_pct <= 25; end
            endcase
            randomize_settings();
            round_start = coeffs_sent;
            while (coeffs_sent - round_start < ROUND_ITEMS)
            begin
                len = $urandom_range(12, 1);
                for (int k = 0; k < len; k++)
                    send_coefficient(random_coefficient(), k == len - 1);
                if ($urandom_range(7) == 0)
                    wait_drained();
            end
            settle();
            round++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
